// File: rtl/core/pale_pkg.sv
`timescale 1ns / 1ps

package pale_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int ADDR_W       = 8;
    localparam int CNT_W        = 9;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 30;

    localparam logic [23:0] GAIN_Q24 = 24'd10187951;
    localparam logic [ANGLE_BITS-1:0] ANGLE_HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_VAR   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0]           x;
        logic [31:0]           y;
        logic [31:0]           slen;
        logic [31:0]           len;
        logic [ANGLE_BITS-1:0] ang;
    } entry_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_FIRST,
        OP_CLEAR,
        OP_RD_LAST,
        OP_DIFF,
        OP_SQ_LOAD_X,
        OP_SQ_LOAD_Y,
        OP_SQ_STEP,
        OP_SQRT_LOAD,
        OP_SQRT_STEP,
        OP_DIST,
        OP_SET_FULL,
        OP_NORM_LOAD,
        OP_NORM_STEP,
        OP_ANG_FOLD,
        OP_ANG_STEP,
        OP_WR_LAST,
        OP_WR_NEW,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_ROT_MUL,
        OP_ROT_FOLD,
        OP_ROT_STEP,
        OP_ROT_OUT,
        OP_VAR_CHK,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic count_zero;
        logic last_entry;
        logic sq_last;
        logic cordic_last;
        logic too_short;
        logic store_full;
        logic norm_done;
        logic scan_hit;
        logic var_stop;
        logic var_fail;
    } dp_stat_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335086;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/pale_ifs.sv
`timescale 1ns / 1ps

interface pale_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic [31:0]        query_offset;
    logic [31:0]        range_end;
    logic [14:0]        angle_limit;

    modport source (output valid, cmd, pt_x, pt_y, query_offset, range_end, angle_limit,
                    input ready);
    modport sink (input valid, cmd, pt_x, pt_y, query_offset, range_end, angle_limit,
                  output ready);
endinterface

interface pale_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_angle;
    logic               variance_ok;
    logic [31:0]        total_len_out;
    logic [8:0]         stored_count;
    logic               store_full;
    logic               path_empty;

    modport source (output valid, out_x, out_y, out_angle, variance_ok, total_len_out,
                    stored_count, store_full, path_empty, input ready);
    modport sink (input valid, out_x, out_y, out_angle, variance_ok, total_len_out,
                  stored_count, store_full, path_empty, output ready);
endinterface

// File: rtl/core/pale_ctrl.sv
`timescale 1ns / 1ps

module pale_ctrl
    import pale_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIRST,
        S_CLEAR,
        S_RD_LAST,
        S_DIFF,
        S_SQX_LOAD,
        S_SQX,
        S_SQY_LOAD,
        S_SQY,
        S_SQRT_LOAD,
        S_SQRT,
        S_DIST,
        S_CHK,
        S_NORM_LOAD,
        S_NORM,
        S_FOLD,
        S_ANG,
        S_WR_LAST,
        S_WR_NEW,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ROT_MUL,
        S_ROT_FOLD,
        S_ROT,
        S_ROT_OUT,
        S_VAR_RD,
        S_VAR_CHK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = OP_IDLE;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.cmd)
                    CMD_ADD:   state_next = stat.count_zero ? S_FIRST : S_RD_LAST;
                    CMD_QUERY: state_next = stat.count_zero ? S_EMIT : S_SCAN_RD;
                    CMD_VAR:   state_next = stat.count_zero ? S_EMIT : S_VAR_RD;
                    CMD_CLEAR: state_next = S_CLEAR;
                    default:   state_next = S_EMIT;
                endcase
            end
            S_FIRST:
            begin
                op         = OP_FIRST;
                state_next = S_EMIT;
            end
            S_CLEAR:
            begin
                op         = OP_CLEAR;
                state_next = S_EMIT;
            end
            S_RD_LAST:
            begin
                op         = OP_RD_LAST;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                op         = OP_DIFF;
                state_next = S_SQX_LOAD;
            end
            S_SQX_LOAD:
            begin
                op         = OP_SQ_LOAD_X;
                state_next = S_SQX;
            end
            S_SQX:
            begin
                op = OP_SQ_STEP;
                if (stat.sq_last)
                    state_next = S_SQY_LOAD;
            end
            S_SQY_LOAD:
            begin
                op         = OP_SQ_LOAD_Y;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                op = OP_SQ_STEP;
                if (stat.sq_last)
                    state_next = S_SQRT_LOAD;
            end
            S_SQRT_LOAD:
            begin
                op         = OP_SQRT_LOAD;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op = OP_SQRT_STEP;
                if (stat.sq_last)
                    state_next = S_DIST;
            end
            S_DIST:
            begin
                op         = OP_DIST;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.too_short)
                    state_next = S_EMIT;
                else if (stat.store_full)
                begin
                    op         = OP_SET_FULL;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_NORM_LOAD;
            end
            S_NORM_LOAD:
            begin
                op         = OP_NORM_LOAD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                op = OP_NORM_STEP;
                if (stat.norm_done)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                op         = OP_ANG_FOLD;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                op = OP_ANG_STEP;
                if (stat.cordic_last)
                    state_next = S_WR_LAST;
            end
            S_WR_LAST:
            begin
                op         = OP_WR_LAST;
                state_next = S_WR_NEW;
            end
            S_WR_NEW:
            begin
                op         = OP_WR_NEW;
                state_next = S_EMIT;
            end
            S_SCAN_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                op         = OP_SCAN_CHK;
                state_next = stat.scan_hit ? S_ROT_MUL : S_SCAN_RD;
            end
            S_ROT_MUL:
            begin
                op         = OP_ROT_MUL;
                state_next = S_ROT_FOLD;
            end
            S_ROT_FOLD:
            begin
                op         = OP_ROT_FOLD;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                op = OP_ROT_STEP;
                if (stat.cordic_last)
                    state_next = S_ROT_OUT;
            end
            S_ROT_OUT:
            begin
                op         = OP_ROT_OUT;
                state_next = S_EMIT;
            end
            S_VAR_RD:
            begin
                op         = OP_SCAN_RD;
                state_next = S_VAR_CHK;
            end
            S_VAR_CHK:
            begin
                op = OP_VAR_CHK;
                if (stat.var_stop || stat.var_fail || stat.last_entry)
                    state_next = S_EMIT;
                else
                    state_next = S_VAR_RD;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/pale_dpath.sv
`timescale 1ns / 1ps

module pale_dpath
    import pale_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_op_t             op,
    output dp_stat_t           stat,
    input  logic [1:0]         in_cmd,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic [31:0]        in_off,
    input  logic [31:0]        in_rend,
    input  logic [14:0]        in_lim,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    output logic signed [31:0] res_x,
    output logic signed [31:0] res_y,
    output logic signed [15:0] res_angle,
    output logic               res_ok,
    output logic [31:0]        res_total,
    output logic [8:0]         res_count,
    output logic               res_full,
    output logic               res_empty
);

    entry_t seg_mem [MAX_SEGMENTS];
    entry_t rdata_reg;

    // control state
    logic [CNT_W-1:0] count_reg;
    logic [31:0]      total_reg;
    logic [31:0]      min_len_reg;

    // word latched at accept
    cmd_t               cmd_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [31:0]        off_reg, rend_reg;
    logic [14:0]        lim_reg;

    logic [CNT_W-1:0] idx_reg;
    logic [5:0]       iter_reg;

    logic signed [32:0] dx_reg, dy_reg;
    logic [65:0]        mcand_reg, acc_reg, n_reg;
    logic [32:0]        mplier_reg, root_reg;
    logic [35:0]        rem_reg;
    logic [31:0]        d_reg;

    logic signed [43:0] vx_reg, vy_reg;
    logic [31:0]        z_reg;

    logic [55:0]        rmul_reg;
    logic signed [59:0] rx_reg, ry_reg;
    logic signed [33:0] rz_reg;

    logic                  have_reg, ok_reg, full_reg;
    logic [ANGLE_BITS-1:0] ref_reg;
    logic signed [31:0]    ox_reg, oy_reg;
    logic signed [15:0]    oa_reg;

    logic signed [31:0] res_x_reg, res_y_reg;
    logic signed [15:0] res_angle_reg;
    logic               res_ok_reg, res_full_reg, res_empty_reg;
    logic [31:0]        res_total_reg;
    logic [8:0]         res_count_reg;

    // ---- combinational helpers ----
    logic [CNT_W-1:0]      cnt_m1;
    logic [32:0]           ax, ay;
    logic [35:0]           rem_sh, trial;
    logic [32:0]           total_sum;
    logic [31:0]           total_sat;
    logic [43:0]           avx, avy;
    logic [4:0]            step_i;
    logic [31:0]           atan_i;
    logic [31:0]           ang_sum;
    logic [ANGLE_BITS-1:0] ang_rnd;
    logic [32:0]           end_sum;
    logic signed [31:0]    t_s;
    logic signed [33:0]    rz_init;
    logic signed [59:0]    rmul_s;
    logic signed [59:0]    rx_rnd, ry_rnd;
    logic signed [35:0]    cx, cy;
    logic signed [37:0]    sum_x, sum_y;
    logic [ANGLE_BITS-1:0] adif, wdif;
    logic [47:0]           wd_cmp, lim_cmp;
    logic                  overlap;
    logic                  rd_en, wr_en;
    logic [ADDR_W-1:0]     raddr, waddr;
    entry_t                wdata;

    function automatic logic [31:0] sat32(input logic signed [37:0] v);
        logic [31:0] r;
        if (v > 38'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -38'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    assign cnt_m1    = count_reg - CNT_W'(1);
    assign ax        = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ay        = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    assign rem_sh    = {rem_reg[33:0], n_reg[65:64]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign total_sum = {1'b0, total_reg} + {1'b0, d_reg};
    assign total_sat = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
    assign avx       = vx_reg[43] ? 44'(-vx_reg) : 44'(vx_reg);
    assign avy       = vy_reg[43] ? 44'(-vy_reg) : 44'(vy_reg);
    assign step_i    = iter_reg[4:0];
    assign atan_i    = atan_turn(step_i);
    assign ang_sum   = z_reg + (32'd1 << (31 - ANGLE_BITS));
    assign ang_rnd   = ang_sum[31 -: ANGLE_BITS];
    assign end_sum   = {1'b0, rdata_reg.slen} + {1'b0, rdata_reg.len};
    assign t_s       = {rdata_reg.ang, {(32 - ANGLE_BITS){1'b0}}};
    assign rz_init   = 34'(t_s);
    assign rmul_s    = {4'b0, rmul_reg};
    assign rx_rnd    = rx_reg + 60'sd8388608;
    assign ry_rnd    = ry_reg + 60'sd8388608;
    assign cx        = rx_rnd[59:24];
    assign cy        = ry_rnd[59:24];
    assign sum_x     = 38'($signed(rdata_reg.x)) + 38'(cx);
    assign sum_y     = 38'($signed(rdata_reg.y)) - 38'(cy);
    assign adif      = rdata_reg.ang - ref_reg;
    assign wdif      = (adif > ANGLE_HALF) ? ANGLE_BITS'(-adif) : adif;
    assign wd_cmp    = 48'({wdif, 16'h0000});
    assign lim_cmp   = 48'({lim_reg, {ANGLE_BITS{1'b0}}});
    assign overlap   = end_sum > {1'b0, off_reg};

    always_comb
    begin
        stat.cmd         = cmd_reg;
        stat.count_zero  = (count_reg == '0);
        stat.last_entry  = (idx_reg == cnt_m1);
        stat.sq_last     = (iter_reg == 6'd32);
        stat.cordic_last = (iter_reg == 6'(CORDIC_STEPS - 1));
        stat.too_short   = (d_reg <= min_len_reg);
        stat.store_full  = (count_reg >= CNT_W'(MAX_SEGMENTS));
        stat.norm_done   = (avx[43:39] != '0) || (avy[43:39] != '0) ||
                           ((vx_reg == '0) && (vy_reg == '0));
        stat.scan_hit    = ({1'b0, off_reg} < end_sum) || (idx_reg == cnt_m1);
        stat.var_stop    = (rdata_reg.slen > rend_reg);
        stat.var_fail    = !stat.var_stop && overlap && have_reg && (wd_cmp > lim_cmp);
    end

    // ---- segment store ----
    always_comb
    begin
        rd_en = (op == OP_RD_LAST) || (op == OP_SCAN_RD);
        raddr = (op == OP_RD_LAST) ? cnt_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
        wr_en = 1'b0;
        waddr = count_reg[ADDR_W-1:0];
        wdata = '{x: px_reg, y: py_reg, slen: total_reg, len: '0, ang: '0};
        case (op)
            OP_FIRST:
            begin
                wr_en = 1'b1;
                waddr = '0;
            end
            OP_WR_LAST:
            begin
                wr_en = 1'b1;
                waddr = cnt_m1[ADDR_W-1:0];
                wdata = '{x: rdata_reg.x, y: rdata_reg.y, slen: total_reg,
                          len: d_reg, ang: ang_rnd};
            end
            OP_WR_NEW:
            begin
                wr_en      = 1'b1;
                wdata.slen = total_sat;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            seg_mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= seg_mem[raddr];
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            total_reg   <= '0;
            min_len_reg <= '0;
            cmd_reg     <= CMD_ADD;
        end
        else
        begin
            if (cfg_wr_en)
                min_len_reg <= cfg_wr_data;
            case (op)
                OP_LOAD:  cmd_reg <= cmd_t'(in_cmd);
                OP_FIRST: count_reg <= CNT_W'(1);
                OP_CLEAR:
                begin
                    count_reg <= '0;
                    total_reg <= '0;
                end
                OP_WR_NEW:
                begin
                    total_reg <= total_sat;
                    count_reg <= count_reg + CNT_W'(1);
                end
                default: count_reg <= count_reg;
            endcase
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                px_reg   <= in_x;
                py_reg   <= in_y;
                off_reg  <= in_off;
                rend_reg <= in_rend;
                lim_reg  <= in_lim;
                idx_reg  <= '0;
                have_reg <= 1'b0;
                ok_reg   <= 1'b1;
                full_reg <= 1'b0;
                ox_reg   <= '0;
                oy_reg   <= '0;
                oa_reg   <= '0;
            end
            OP_DIFF:
            begin
                dx_reg <= {px_reg[31], px_reg} - {rdata_reg.x[31], rdata_reg.x};
                dy_reg <= {py_reg[31], py_reg} - {rdata_reg.y[31], rdata_reg.y};
            end
            OP_SQ_LOAD_X:
            begin
                mcand_reg  <= 66'(ax);
                mplier_reg <= ax;
                acc_reg    <= '0;
                iter_reg   <= '0;
            end
            OP_SQ_LOAD_Y:
            begin
                mcand_reg  <= 66'(ay);
                mplier_reg <= ay;
                iter_reg   <= '0;
            end
            OP_SQ_STEP:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[64:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[32:1]};
                iter_reg   <= iter_reg + 6'd1;
            end
            OP_SQRT_LOAD:
            begin
                n_reg    <= acc_reg;
                rem_reg  <= '0;
                root_reg <= '0;
                iter_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
                n_reg    <= {n_reg[63:0], 2'b00};
                iter_reg <= iter_reg + 6'd1;
            end
            OP_DIST: d_reg <= root_reg[32] ? 32'hFFFF_FFFF : root_reg[31:0];
            OP_SET_FULL: full_reg <= 1'b1;
            OP_NORM_LOAD:
            begin
                vx_reg <= 44'(dx_reg);
                vy_reg <= -(44'(dy_reg));
            end
            OP_NORM_STEP:
            begin
                if (!stat.norm_done)
                begin
                    vx_reg <= vx_reg <<< 1;
                    vy_reg <= vy_reg <<< 1;
                end
            end
            OP_ANG_FOLD:
            begin
                if (vx_reg[43])
                begin
                    z_reg  <= 32'h8000_0000;
                    vx_reg <= -vx_reg;
                    vy_reg <= -vy_reg;
                end
                else
                    z_reg <= '0;
                iter_reg <= '0;
            end
            OP_ANG_STEP:
            begin
                if (vy_reg > 44'sd0)
                begin
                    vx_reg <= vx_reg + (vy_reg >>> step_i);
                    vy_reg <= vy_reg - (vx_reg >>> step_i);
                    z_reg  <= z_reg + atan_i;
                end
                else
                begin
                    vx_reg <= vx_reg - (vy_reg >>> step_i);
                    vy_reg <= vy_reg + (vx_reg >>> step_i);
                    z_reg  <= z_reg - atan_i;
                end
                iter_reg <= iter_reg + 6'd1;
            end
            OP_SCAN_CHK:
            begin
                if (!stat.scan_hit)
                    idx_reg <= idx_reg + CNT_W'(1);
            end
            OP_ROT_MUL: rmul_reg <= (off_reg - rdata_reg.slen) * GAIN_Q24;
            OP_ROT_FOLD:
            begin
                if (rz_init > 34'sd1073741824)
                begin
                    rz_reg <= rz_init - 34'sd2147483648;
                    rx_reg <= -rmul_s;
                end
                else if (rz_init < -34'sd1073741824)
                begin
                    rz_reg <= rz_init + 34'sd2147483648;
                    rx_reg <= -rmul_s;
                end
                else
                begin
                    rz_reg <= rz_init;
                    rx_reg <= rmul_s;
                end
                ry_reg   <= '0;
                iter_reg <= '0;
            end
            OP_ROT_STEP:
            begin
                if (rz_reg >= 34'sd0)
                begin
                    rx_reg <= rx_reg - (ry_reg >>> step_i);
                    ry_reg <= ry_reg + (rx_reg >>> step_i);
                    rz_reg <= rz_reg - $signed({2'b00, atan_i});
                end
                else
                begin
                    rx_reg <= rx_reg + (ry_reg >>> step_i);
                    ry_reg <= ry_reg - (rx_reg >>> step_i);
                    rz_reg <= rz_reg + $signed({2'b00, atan_i});
                end
                iter_reg <= iter_reg + 6'd1;
            end
            OP_ROT_OUT:
            begin
                ox_reg <= sat32(sum_x);
                oy_reg <= sat32(sum_y);
                oa_reg <= 16'($signed(rdata_reg.ang));
            end
            OP_VAR_CHK:
            begin
                if (!stat.var_stop && overlap && !have_reg)
                begin
                    ref_reg  <= rdata_reg.ang;
                    have_reg <= 1'b1;
                end
                if (stat.var_fail)
                    ok_reg <= 1'b0;
                if (!stat.var_stop && !stat.var_fail)
                    idx_reg <= idx_reg + CNT_W'(1);
            end
            OP_EMIT:
            begin
                res_x_reg     <= ox_reg;
                res_y_reg     <= oy_reg;
                res_angle_reg <= oa_reg;
                res_ok_reg    <= (cmd_reg == CMD_VAR) && ok_reg;
                res_total_reg <= total_reg;
                res_count_reg <= count_reg;
                res_full_reg  <= full_reg;
                res_empty_reg <= (count_reg == '0);
            end
            default: iter_reg <= iter_reg;
        endcase
    end

    assign res_x     = res_x_reg;
    assign res_y     = res_y_reg;
    assign res_angle = res_angle_reg;
    assign res_ok    = res_ok_reg;
    assign res_total = res_total_reg;
    assign res_count = res_count_reg;
    assign res_full  = res_full_reg;
    assign res_empty = res_empty_reg;

endmodule

// File: rtl/core/polyline_arc_length_engine.sv
// Flow from accept to result valid: an add runs two 33-step serial squares,
//   a 33-step root, up to 39 normalize shifts and a 30-step CORDIC; a short step or a full
//   store ends after the root; a query scans entries and then rotates; the variance test
//   scans entries; clear, first point and an empty path query or test go straight to the result.
// One word in flight; the next word is accepted once the result loads; a stalled result
//   holds only the next result. Reset clears control, count, total, min_segment_length.
`timescale 1ns / 1ps

module polyline_arc_length_engine
    import pale_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pale_in_if.sink     item,
    pale_out_if.source  result,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);

    dp_op_t   op;
    dp_stat_t stat;

    pale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .op        (op)
    );

    pale_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stat        (stat),
        .in_cmd      (item.cmd),
        .in_x        (item.pt_x),
        .in_y        (item.pt_y),
        .in_off      (item.query_offset),
        .in_rend     (item.range_end),
        .in_lim      (item.angle_limit),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_x       (result.out_x),
        .res_y       (result.out_y),
        .res_angle   (result.out_angle),
        .res_ok      (result.variance_ok),
        .res_total   (result.total_len_out),
        .res_count   (result.stored_count),
        .res_full    (result.store_full),
        .res_empty   (result.path_empty)
    );

endmodule

// File: rtl/core/pale_checker.sv
`timescale 1ns / 1ps

module pale_checker
    import pale_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [15:0] out_angle,
    input logic [31:0]        total_len_out,
    input logic [8:0]         stored_count,
    input logic               store_full,
    input logic               path_empty
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
        $stable(out_angle) && $stable(total_len_out) && $stable(stored_count))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stored_count <= CNT_W'(MAX_SEGMENTS))
        else $error("stored count above capacity");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_empty |-> stored_count == '0 && total_len_out == '0)
        else $error("empty path with length or entries");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && store_full |-> stored_count == CNT_W'(MAX_SEGMENTS))
        else $error("store full flagged below capacity");

endmodule

bind polyline_arc_length_engine pale_checker u_pale_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_x         (result.out_x),
    .out_y         (result.out_y),
    .out_angle     (result.out_angle),
    .total_len_out (result.total_len_out),
    .stored_count  (result.stored_count),
    .store_full    (result.store_full),
    .path_empty    (result.path_empty)
);
